// File: rtl/drs_pkg.sv
package drs_pkg;

   // register file
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ETA = 1'b1;

   localparam int IOR_W = 14;
   localparam int ETA_W = 16;
   localparam logic [IOR_W-1:0] IOR_RESET = 14'd6144;
   localparam logic [ETA_W-1:0] ETA_RESET = 16'd43691;
   localparam logic [IOR_W-1:0] IOR_ONE   = 14'd4096;

   // schlick base reflectance, q0.16 with room for 1.0
   localparam int R0_W = 17;

   // square root unit
   localparam int SQ_IN_W   = 44;
   localparam int SQ_ROOT_W = 22;
   localparam int SQ_ITER   = 2;
   localparam int SQ_STAGES = 11;

   typedef enum logic [1:0] {
      KIND_REFRACT = 2'd0,
      KIND_FRESNEL = 2'd1,
      KIND_TIR     = 2'd2
   } kind_type;

endpackage

// File: rtl/drs_isqrt.sv
module drs_isqrt (
   input  logic                           clock,
   input  logic [drs_pkg::SQ_IN_W-1:0]    radicand,
   output logic [drs_pkg::SQ_ROOT_W-1:0]  root
);

   localparam int IN_W   = drs_pkg::SQ_IN_W;
   localparam int ROOT_W = drs_pkg::SQ_ROOT_W;
   localparam int REM_W  = drs_pkg::SQ_ROOT_W + 2;
   localparam int STAGES = drs_pkg::SQ_STAGES;
   localparam int ITER   = drs_pkg::SQ_ITER;

   logic [IN_W-1:0]   opnd_ff [STAGES];
   logic [IN_W-1:0]   opnd_in [STAGES];
   logic [REM_W-1:0]  rem_ff  [STAGES];
   logic [REM_W-1:0]  rem_in  [STAGES];
   logic [ROOT_W-1:0] root_ff [STAGES];
   logic [ROOT_W-1:0] root_in [STAGES];

   // restoring digit recurrence, two result bits per stage
   always_comb begin
      logic [IN_W-1:0]   opnd;
      logic [REM_W-1:0]  rem;
      logic [REM_W-1:0]  trial;
      logic [ROOT_W-1:0] rt;
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            opnd = radicand;
            rem  = '0;
            rt   = '0;
         end else begin
            opnd = opnd_ff[s-1];
            rem  = rem_ff[s-1];
            rt   = root_ff[s-1];
         end
         for (int j = 0; j < ITER; j++) begin
            rem   = {rem[REM_W-3:0], opnd[IN_W-1 -: 2]};
            opnd  = {opnd[IN_W-3:0], 2'b00};
            trial = {rt, 2'b01};
            if (rem >= trial) begin
               rem = rem - trial;
               rt  = {rt[ROOT_W-2:0], 1'b1};
            end else begin
               rt  = {rt[ROOT_W-2:0], 1'b0};
            end
         end
         opnd_in[s] = opnd;
         rem_in[s]  = rem;
         root_in[s] = rt;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         opnd_ff[s] <= opnd_in[s];
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
      end
   end

   assign root = root_ff[STAGES-1];

endmodule

// File: rtl/drs_r0_unit.sv
module drs_r0_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        ior_load,
   input  logic [drs_pkg::IOR_W-1:0]   ior,
   output logic                        busy,
   output logic [drs_pkg::R0_W-1:0]    r0
);

   localparam int IOR_W = drs_pkg::IOR_W;
   localparam int Q_W   = drs_pkg::R0_W;
   localparam int DVD_W = 30;
   localparam int DEN_W = 15;
   localparam int STEPS = 30;
   localparam int CNT_W = 5;
   localparam int SQ_W  = 2 * Q_W + 1;

   typedef enum logic [3:0] {
      DIV_LOAD   = 4'b0001,
      DIV_RUN    = 4'b0010,
      DIV_SQUARE = 4'b0100,
      DIV_IDLE   = 4'b1000
   } div_state_type;

   div_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [Q_W-1:0]    quo_ff, quo_in;
   logic [Q_W-1:0]    r0_ff, r0_in;

   logic [IOR_W-1:0]  num;
   logic [DEN_W-1:0]  den;
   logic [DEN_W:0]    trial;
   logic [SQ_W-1:0]   sq_rnd;

   assign num    = (ior >= drs_pkg::IOR_ONE) ? ior - drs_pkg::IOR_ONE : drs_pkg::IOR_ONE - ior;
   assign den    = DEN_W'(ior) + DEN_W'(drs_pkg::IOR_ONE);
   assign trial  = {rem_ff, dvd_ff[DVD_W-1]};
   assign sq_rnd = SQ_W'(quo_ff) * SQ_W'(quo_ff) + SQ_W'(32768);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      r0_in    = r0_ff;
      case (state_ff)
         DIV_LOAD: begin
            // |ior-1| / (ior+1) in q0.16, rounded to nearest
            dvd_in   = {num, 16'b0} + DVD_W'(den[DEN_W-1:1]);
            den_in   = den;
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = CNT_W'(STEPS - 1);
            state_in = DIV_RUN;
         end
         DIV_RUN: begin
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, den_ff}) begin
               rem_in = DEN_W'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DEN_W-1:0];
               quo_in = {quo_ff[Q_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = DIV_SQUARE;
            end
         end
         DIV_SQUARE: begin
            r0_in    = sq_rnd[Q_W+15:16];
            state_in = DIV_IDLE;
         end
         DIV_IDLE: begin
            state_in = DIV_IDLE;
         end
         default: begin
            state_in = DIV_LOAD;
         end
      endcase
      if (ior_load) begin
         state_in = DIV_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_LOAD;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      r0_ff  <= r0_in;
   end

   assign busy = (state_ff != DIV_IDLE);
   assign r0   = r0_ff;

endmodule

// File: rtl/dielectric_refract_schlick_core.sv
// dielectric scatter core: snell refraction with a schlick fresnel choice
//
// input: pulse start with the ray on the req_ ports (direction, normal, both
// q1.14, and a q0.16 random fraction). an item is taken at a clock edge with
// start high and busy low. one item can be taken every cycle while busy is low.
// output: one result per item, shown for exactly one cycle with rsp_valid
// high, in input order. the receiver cannot stall, so results never wait
// and nothing is dropped.
// config: csr_we writes csr_wdata into register csr_index (0 index of
// refraction q2.12, 1 its reciprocal q0.16); the user writes only while no
// items are in flight, the block does not enforce it. busy: after reset and
// after each write of the index of refraction a serial divider recomputes
// the schlick base reflectance r0, during which busy is high and no item is taken.
// pipeline: 19 register stages; the 11-stage square root (two result bits
// per stage) sets the depth, the schlick power chain runs beside it.
// reset: synchronous, clears all valid bits and reloads both registers.
module dielectric_refract_schlick_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [15:0]               req_dir_x,
   input  logic signed [15:0]               req_dir_y,
   input  logic signed [15:0]               req_dir_z,
   input  logic signed [15:0]               req_norm_x,
   input  logic signed [15:0]               req_norm_y,
   input  logic signed [15:0]               req_norm_z,
   input  logic [15:0]                      req_random_fraction,
   output logic                             rsp_valid,
   output logic signed [15:0]               rsp_out_x,
   output logic signed [15:0]               rsp_out_y,
   output logic signed [15:0]               rsp_out_z,
   output logic [1:0]                       rsp_scatter_kind,
   input  logic                             csr_we,
   input  logic [drs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [15:0]                      csr_wdata
);

   localparam int LAT     = 19;
   localparam int LATE_N  = 13;   // carry from stage 5 to stage 17
   localparam int KIND_N  = 7;    // kind from stage 11 to stage 17
   localparam int IOR_W   = drs_pkg::IOR_W;
   localparam int ETA_W   = drs_pkg::ETA_W;
   localparam int R0_W    = drs_pkg::R0_W;
   localparam int ROOT_W  = drs_pkg::SQ_ROOT_W;
   localparam int C28_W   = 34;
   localparam int C14_W   = 19;
   localparam int SQ_W    = 38;
   localparam int E2_W    = 21;
   localparam int X_W     = 22;
   localparam int CN_W    = 35;
   localparam int T_W     = 18;
   localparam int V_W     = 36;
   localparam int REFL_W  = 23;
   localparam int PH_W    = 42;
   localparam int PL_W    = 39;
   localparam int ES_W    = 60;
   localparam int K_W     = 46;
   localparam int P_W     = 28;
   localparam int PR_W    = 46;
   localparam int PROB_W  = 32;
   localparam int M1_W    = 53;
   localparam int M2_W    = 39;
   localparam int SUM_W   = 58;

   typedef struct {
      logic signed [V_W-1:0]    v28  [3];
      logic signed [REFL_W-1:0] refl [3];
      logic signed [15:0]       n    [3];
      logic                     leave;
   } late_type;

   // saturate to the 16-bit output range
   function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [15:0] r;
      if (v > SUM_W'(32767)) begin
         r = 16'sh7fff;
      end else if (v < -SUM_W'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // one step of the schlick power chain: rnd(p*t, 14)
   function automatic logic signed [P_W-1:0] sch_step(input logic signed [P_W-1:0] p,
                                                      input logic signed [T_W-1:0] t);
      logic signed [P_W+T_W-1:0] pm;
      logic signed [P_W+T_W-1:0] pr;
      pm = (P_W+T_W)'(p) * (P_W+T_W)'(t);
      pr = (pm + (P_W+T_W)'(8192)) >>> 14;
      return P_W'(pr);
   endfunction

   // ---------------------------------------------------------------- registers
   logic [IOR_W-1:0] ior_ff;
   logic [ETA_W-1:0] eta_ff;
   logic             ior_load;
   logic             r0_busy;
   logic [R0_W-1:0]  r0;
   logic             accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         ior_ff <= drs_pkg::IOR_RESET;
         eta_ff <= drs_pkg::ETA_RESET;
      end else if (csr_we) begin
         case (csr_index)
            drs_pkg::CSR_IOR: ior_ff <= csr_wdata[IOR_W-1:0];
            drs_pkg::CSR_ETA: eta_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign ior_load = csr_we && (csr_index == drs_pkg::CSR_IOR);

   drs_r0_unit u_r0 (
      .clock    (clock),
      .reset    (reset),
      .ior_load (ior_load),
      .ior      (ior_ff),
      .busy     (r0_busy),
      .r0       (r0)
   );

   assign busy   = r0_busy;
   assign accept = start && !r0_busy;

   // valid bits, one per stage
   logic [LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic signed [15:0] in_d [3];
   logic signed [15:0] in_n [3];
   logic signed [15:0] s1_d_ff  [3];
   logic signed [15:0] s1_n_ff  [3];
   logic signed [31:0] s1_dn_ff [3];
   logic [15:0]        s1_u_ff;

   assign in_d[0] = req_dir_x;
   assign in_d[1] = req_dir_y;
   assign in_d[2] = req_dir_z;
   assign in_n[0] = req_norm_x;
   assign in_n[1] = req_norm_y;
   assign in_n[2] = req_norm_z;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s1_d_ff[i]  <= in_d[i];
         s1_n_ff[i]  <= in_n[i];
         s1_dn_ff[i] <= 32'(in_d[i]) * 32'(in_n[i]);
      end
      s1_u_ff <= req_random_fraction;
   end

   // ---------------------------------------------------------------- stage 2
   // dot product, its q1.14 rounding and the side of the surface
   logic signed [C28_W-1:0] c28;
   logic signed [C28_W-1:0] c28_rnd;
   logic signed [C14_W-1:0] s2_c14_ff;
   logic                    s2_leave_ff;
   logic signed [15:0]      s2_d_ff [3];
   logic signed [15:0]      s2_n_ff [3];
   logic [15:0]             s2_u_ff;

   assign c28     = C28_W'(s1_dn_ff[0]) + C28_W'(s1_dn_ff[1]) + C28_W'(s1_dn_ff[2]);
   assign c28_rnd = (c28 + C28_W'(8192)) >>> 14;

   always_ff @(posedge clock) begin
      s2_c14_ff   <= C14_W'(c28_rnd);
      s2_leave_ff <= !c28[C28_W-1] && (c28 != '0);
      s2_d_ff     <= s1_d_ff;
      s2_n_ff     <= s1_n_ff;
      s2_u_ff     <= s1_u_ff;
   end

   // ---------------------------------------------------------------- stage 3
   logic [27:0]               ior_sq;
   logic [28:0]               ior_sq_rnd;
   logic [31:0]               eta_sq;
   logic [32:0]               eta_sq_rnd;
   logic signed [33:0]        ior_c;
   logic signed [33:0]        ior_c_rnd;
   logic signed [SQ_W-1:0]    s3_sq_ff;
   logic [E2_W-1:0]           s3_e2_ff;
   logic signed [X_W-1:0]     s3_x14_ff;
   logic signed [CN_W-1:0]    s3_cn_ff [3];
   logic signed [15:0]        s3_d_ff [3];
   logic signed [15:0]        s3_n_ff [3];
   logic [15:0]               s3_u_ff;
   logic                      s3_leave_ff;

   assign ior_sq     = 28'(ior_ff) * 28'(ior_ff);
   assign ior_sq_rnd = 29'(ior_sq) + 29'd128;
   assign eta_sq     = 32'(eta_ff) * 32'(eta_ff);
   assign eta_sq_rnd = 33'(eta_sq) + 33'd32768;
   assign ior_c      = 34'($signed({1'b0, ior_ff})) * 34'(s2_c14_ff);
   assign ior_c_rnd  = (ior_c + 34'sd2048) >>> 12;

   always_ff @(posedge clock) begin
      s3_sq_ff <= SQ_W'(s2_c14_ff) * SQ_W'(s2_c14_ff);
      if (s2_leave_ff) begin
         // leaving: squared ratio is ior^2, q.16
         s3_e2_ff  <= ior_sq_rnd[28:8];
         s3_x14_ff <= X_W'(ior_c_rnd);
      end else begin
         s3_e2_ff  <= E2_W'(eta_sq_rnd[32:16]);
         s3_x14_ff <= -X_W'(s2_c14_ff);
      end
      for (int i = 0; i < 3; i++) begin
         s3_cn_ff[i] <= CN_W'(s2_c14_ff) * CN_W'(s2_n_ff[i]);
      end
      s3_d_ff     <= s2_d_ff;
      s3_n_ff     <= s2_n_ff;
      s3_u_ff     <= s2_u_ff;
      s3_leave_ff <= s2_leave_ff;
   end

   // ---------------------------------------------------------------- stage 4
   logic signed [X_W:0]     t_raw;
   logic signed [T_W-1:0]   t_clamp;
   logic signed [V_W-1:0]   refl_rc [3];
   logic signed [SQ_W-1:0]  s4_s28_ff;
   logic signed [T_W-1:0]   s4_t14_ff;
   logic [E2_W-1:0]         s4_e2_ff;
   logic [15:0]             s4_u_ff;
   late_type                s4_late_ff;

   assign t_raw = (X_W+1)'(16384) - (X_W+1)'(s3_x14_ff);

   // schlick base clamped to [-4.0, 1.0]
   always_comb begin
      if (t_raw > (X_W+1)'(16384)) begin
         t_clamp = T_W'(16384);
      end else if (t_raw < -(X_W+1)'(65536)) begin
         t_clamp = -T_W'(65536);
      end else begin
         t_clamp = T_W'(t_raw);
      end
      for (int i = 0; i < 3; i++) begin
         refl_rc[i] = ($signed({s3_cn_ff[i], 1'b0}) + V_W'(8192)) >>> 14;
      end
   end

   always_ff @(posedge clock) begin
      s4_s28_ff <= SQ_W'(268435456) - s3_sq_ff;
      s4_t14_ff <= t_clamp;
      s4_e2_ff  <= s3_e2_ff;
      s4_u_ff   <= s3_u_ff;
      for (int i = 0; i < 3; i++) begin
         s4_late_ff.refl[i] <= REFL_W'(s3_d_ff[i]) - REFL_W'(refl_rc[i]);
         s4_late_ff.v28[i]  <= (V_W'(s3_d_ff[i]) <<< 14) - V_W'(s3_cn_ff[i]);
      end
      s4_late_ff.n     <= s3_n_ff;
      s4_late_ff.leave <= s3_leave_ff;
   end

   // ---------------------------------------------------------------- stage 5
   // e2 * s28 cut into two partial products
   logic signed [19:0]     s28_hi;
   logic [17:0]            s28_lo;
   logic signed [PH_W-1:0] s5_ph_ff;
   logic [PL_W-1:0]        s5_pl_ff;
   logic signed [P_W-1:0]  s5_p_ff;
   logic signed [T_W-1:0]  s5_t14_ff;
   logic [15:0]            s5_u_ff;

   // carried data, late_ff[k] sits at stage 5+k, kind_ff[k] at stage 11+k
   late_type          late_ff [LATE_N];
   drs_pkg::kind_type kind_ff [KIND_N];

   assign s28_hi = s4_s28_ff[SQ_W-1:18];
   assign s28_lo = s4_s28_ff[17:0];

   always_ff @(posedge clock) begin
      s5_ph_ff  <= PH_W'(s28_hi) * PH_W'($signed({1'b0, s4_e2_ff}));
      s5_pl_ff  <= PL_W'(s28_lo) * PL_W'(s4_e2_ff);
      s5_p_ff   <= sch_step(P_W'(s4_t14_ff), s4_t14_ff);
      s5_t14_ff <= s4_t14_ff;
      s5_u_ff   <= s4_u_ff;
   end

   // ---------------------------------------------------------------- stage 6
   // discriminant k28 and total internal reflection
   logic signed [ES_W-1:0] es;
   logic signed [ES_W-1:0] es_rnd;
   logic signed [K_W-1:0]  k28;
   logic signed [K_W-1:0]  s6_k28_ff;
   logic                   s6_tir_ff;
   logic signed [P_W-1:0]  s6_p_ff;
   logic signed [T_W-1:0]  s6_t14_ff;
   logic [15:0]            s6_u_ff;
   logic [drs_pkg::SQ_IN_W-1:0] radicand;
   logic [ROOT_W-1:0]      root;

   assign es     = (ES_W'(s5_ph_ff) <<< 18) + ES_W'($signed({1'b0, s5_pl_ff}));
   assign es_rnd = (es + ES_W'(32768)) >>> 16;
   assign k28    = K_W'(268435456) - K_W'(es_rnd);

   always_ff @(posedge clock) begin
      s6_k28_ff <= k28;
      s6_tir_ff <= late_ff[0].leave && (k28[K_W-1] || (k28 == '0));
      s6_p_ff   <= sch_step(s5_p_ff, s5_t14_ff);
      s6_t14_ff <= s5_t14_ff;
      s6_u_ff   <= s5_u_ff;
   end

   // negative discriminant reads as zero
   assign radicand = (s6_k28_ff[K_W-1] || (s6_k28_ff == '0)) ? '0
                     : s6_k28_ff[drs_pkg::SQ_IN_W-1:0];

   // stages 7 to 17
   drs_isqrt u_isqrt (
      .clock    (clock),
      .radicand (radicand),
      .root     (root)
   );

   // ---------------------------------------------------------------- stages 7 to 10
   // rest of the schlick chain and the fresnel draw
   logic signed [P_W-1:0]    s7_p_ff, s8_p_ff;
   logic signed [T_W-1:0]    s7_t14_ff;
   logic [15:0]              s7_u_ff, s8_u_ff, s9_u_ff;
   logic                     s7_tir_ff, s8_tir_ff, s9_tir_ff;
   logic [R0_W-1:0]          one_minus_r0;
   logic signed [PR_W-1:0]   s9_pr_ff;
   logic signed [PR_W-1:0]   pr_rnd;
   logic signed [PROB_W-1:0] prob;
   drs_pkg::kind_type        s10_kind_ff;

   assign one_minus_r0 = R0_W'((R0_W+1)'(65536) - (R0_W+1)'(r0));
   assign pr_rnd       = (s9_pr_ff + PR_W'(8192)) >>> 14;
   assign prob         = PROB_W'($signed({1'b0, r0})) + PROB_W'(pr_rnd);

   always_ff @(posedge clock) begin
      s7_p_ff   <= sch_step(s6_p_ff, s6_t14_ff);
      s7_t14_ff <= s6_t14_ff;
      s7_u_ff   <= s6_u_ff;
      s7_tir_ff <= s6_tir_ff;
      s8_p_ff   <= sch_step(s7_p_ff, s7_t14_ff);
      s8_u_ff   <= s7_u_ff;
      s8_tir_ff <= s7_tir_ff;
      s9_pr_ff  <= PR_W'($signed({1'b0, one_minus_r0})) * PR_W'(s8_p_ff);
      s9_u_ff   <= s8_u_ff;
      s9_tir_ff <= s8_tir_ff;
      if (s9_tir_ff) begin
         s10_kind_ff <= drs_pkg::KIND_TIR;
      end else if (PROB_W'($signed({1'b0, s9_u_ff})) < prob) begin
         s10_kind_ff <= drs_pkg::KIND_FRESNEL;
      end else begin
         s10_kind_ff <= drs_pkg::KIND_REFRACT;
      end
   end

   // ---------------------------------------------------------------- delay lines
   always_ff @(posedge clock) begin
      late_ff[0] <= s4_late_ff;
      for (int k = 1; k < LATE_N; k++) begin
         late_ff[k] <= late_ff[k-1];
      end
      kind_ff[0] <= s10_kind_ff;
      for (int k = 1; k < KIND_N; k++) begin
         kind_ff[k] <= kind_ff[k-1];
      end
   end

   // ---------------------------------------------------------------- stage 18
   logic signed [17:0]     scale;
   logic signed [M1_W-1:0] s18_m1_ff [3];
   logic signed [M2_W-1:0] s18_m2_ff [3];
   logic signed [REFL_W-1:0] s18_refl_ff [3];
   logic                   s18_leave_ff;
   drs_pkg::kind_type      s18_kind_ff;

   assign scale = late_ff[LATE_N-1].leave ? 18'($signed({1'b0, ior_ff}))
                                          : 18'($signed({1'b0, eta_ff}));

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s18_m1_ff[i] <= M1_W'(scale) * M1_W'(late_ff[LATE_N-1].v28[i]);
         s18_m2_ff[i] <= M2_W'(late_ff[LATE_N-1].n[i]) * M2_W'($signed({1'b0, root}));
      end
      s18_refl_ff  <= late_ff[LATE_N-1].refl;
      s18_leave_ff <= late_ff[LATE_N-1].leave;
      s18_kind_ff  <= kind_ff[KIND_N-1];
   end

   // ---------------------------------------------------------------- stage 19
   logic signed [SUM_W-1:0] refr_sum [3];
   logic signed [SUM_W-1:0] sel      [3];
   logic signed [15:0]      out_ff   [3];
   drs_pkg::kind_type       kind_out_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s18_leave_ff) begin
            refr_sum[i] = (SUM_W'(s18_m1_ff[i]) + (SUM_W'(s18_m2_ff[i]) <<< 12)
                           + SUM_W'(33554432)) >>> 26;
         end else begin
            refr_sum[i] = (SUM_W'(s18_m1_ff[i]) - (SUM_W'(s18_m2_ff[i]) <<< 16)
                           + SUM_W'(536870912)) >>> 30;
         end
         sel[i] = (s18_kind_ff == drs_pkg::KIND_REFRACT) ? refr_sum[i]
                                                         : SUM_W'(s18_refl_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         out_ff[i] <= sat16(sel[i]);
      end
      kind_out_ff <= s18_kind_ff;
   end

   assign rsp_valid        = vld_ff[LAT-1];
   assign rsp_out_x        = out_ff[0];
   assign rsp_out_y        = out_ff[1];
   assign rsp_out_z        = out_ff[2];
   assign rsp_scatter_kind = kind_out_ff;

`ifndef ASSERT_OFF
   // every result goes back to an item taken a fixed latency earlier
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a matching item");

   // total internal reflection only on a ray leaving the surface
   a_tir_leaving: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAT-3] && kind_ff[KIND_N-1] == drs_pkg::KIND_TIR)
         |-> late_ff[LATE_N-1].leave)
      else $error("kind and carried data out of step");

   // a new index of refraction blocks items until r0 is rebuilt
   a_ior_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == drs_pkg::CSR_IOR) |=> busy)
      else $error("not busy after index write");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   // one ray as presented on the req_ ports
   typedef struct packed {
      logic signed [15:0] dx, dy, dz;
      logic signed [15:0] nx, ny, nz;
      logic [15:0]        frac;
   } ray_type;

   // one scattered ray as seen on the rsp_ ports
   typedef struct packed {
      logic signed [15:0] ox, oy, oz;
      drs_pkg::kind_type  kind;
   } scat_type;

   localparam int LATENCY = 19;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic signed [15:0] req_norm_x = '0, req_norm_y = '0, req_norm_z = '0;
   logic [15:0] req_random_fraction = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [1:0] rsp_scatter_kind;
   logic csr_we = 1'b0;
   logic [drs_pkg::CSR_IDX_W-1:0] csr_index = drs_pkg::CSR_IOR;
   logic [15:0] csr_wdata = '0;

   dielectric_refract_schlick_core dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor copy of the two registers
   longint ior_q412 = longint'(drs_pkg::IOR_RESET);
   longint eta_q016 = longint'(drs_pkg::ETA_RESET);

   ray_type  ray_queue[$];      // items waiting to be driven
   scat_type scatter_queue[$];  // predicted scatters, oldest first
   int    errors = 0;
   bit    feeding = 1'b0;

   // round to nearest, ties toward +inf
   function automatic longint rshift_rnd(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r = 0;
      longint b = longint'(1) << 62;
      if (v <= 0) return 0;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic scat_type scatter_ray(ray_type r);
      longint d[3], n[3], o[3];
      longint c28, c14, s28, e2, k28, root14, x14, t14, p, r0, q16, num, den, prob, v28;
      bit leaving;
      drs_pkg::kind_type kind;
      scat_type res;
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      n[0] = r.nx; n[1] = r.ny; n[2] = r.nz;
      c28 = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
      c14 = rshift_rnd(c28, 14);
      s28 = (longint'(1) << 28) - c14 * c14;
      leaving = c28 > 0;
      e2 = leaving ? rshift_rnd(ior_q412 * ior_q412, 8) : rshift_rnd(eta_q016 * eta_q016, 16);
      k28 = (longint'(1) << 28) - rshift_rnd(e2 * s28, 16);
      if (leaving && k28 <= 0) begin
         kind = drs_pkg::KIND_TIR;
      end else begin
         // schlick reflectance against the random fraction
         x14 = leaving ? rshift_rnd(ior_q412 * c14, 12) : -c14;
         num = ior_q412 - 4096;
         if (num < 0) num = -num;
         den = ior_q412 + 4096;
         q16 = (num * 65536 + den / 2) / den;
         r0 = rshift_rnd(q16 * q16, 16);
         t14 = 16384 - x14;
         if (t14 > 16384) t14 = 16384;
         if (t14 < -65536) t14 = -65536;
         p = t14;
         repeat (4) p = rshift_rnd(p * t14, 14);
         prob = r0 + rshift_rnd((65536 - r0) * p, 14);
         kind = (longint'(r.frac) < prob) ? drs_pkg::KIND_FRESNEL : drs_pkg::KIND_REFRACT;
      end
      if (kind != drs_pkg::KIND_REFRACT) begin
         for (int i = 0; i < 3; i++) o[i] = d[i] - rshift_rnd(2 * c14 * n[i], 14);
      end else begin
         root14 = int_sqrt(k28);
         for (int i = 0; i < 3; i++) begin
            v28 = d[i] * 16384 - c14 * n[i];
            if (leaving) o[i] = rshift_rnd(ior_q412 * v28 + n[i] * root14 * 4096, 26);
            else o[i] = rshift_rnd(eta_q016 * v28 - n[i] * root14 * 65536, 30);
         end
      end
      res.ox = clip16(o[0]);
      res.oy = clip16(o[1]);
      res.oz = clip16(o[2]);
      res.kind = kind;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // driver: bursts of items with random gaps in between
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      ray_type r;
      if (!reset) begin
         if (start && !busy) begin
            scatter_queue.push_back(scatter_ray(ray_queue.pop_front()));
         end
         if (start && busy) begin
            // item still waiting, keep it on the ports
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (feeding && ray_queue.size() > 0) begin
            r = ray_queue[0];
            start <= 1'b1;
            {req_dir_x, req_dir_y, req_dir_z, req_norm_x, req_norm_y, req_norm_z,
             req_random_fraction} <= r;
            if (burst_left <= 1) begin
               burst_left <= int'($urandom_range(1, 30));
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe is compared with the oldest prediction
   always @(posedge clock) begin
      scat_type w;
      if (!reset && rsp_valid) begin
         if (scatter_queue.size() == 0) begin
            report_mismatch("unexpected item", 0, 0);
         end else begin
            w = scatter_queue.pop_front();
            if (rsp_out_x !== w.ox) report_mismatch("out_x", rsp_out_x, w.ox);
            if (rsp_out_y !== w.oy) report_mismatch("out_y", rsp_out_y, w.oy);
            if (rsp_out_z !== w.oz) report_mismatch("out_z", rsp_out_z, w.oz);
            if (rsp_scatter_kind !== w.kind)
               report_mismatch("scatter_kind", rsp_scatter_kind, w.kind);
         end
      end
   end

   function automatic logic signed [15:0] rand_comp();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   // roughly unit vector from random components
   function automatic void unit_vec(output logic signed [15:0] x, y, z);
      real a, b, c, m;
      a = real'($signed($urandom_range(0, 2000))) - 1000.0;
      b = real'($signed($urandom_range(0, 2000))) - 1000.0;
      c = real'($signed($urandom_range(0, 2000))) - 1000.0;
      m = $sqrt(a * a + b * b + c * c);
      if (m < 1.0) begin a = 1000.0; m = 1000.0; end
      x = 16'($rtoi(a / m * 16384.0));
      y = 16'($rtoi(b / m * 16384.0));
      z = 16'($rtoi(c / m * 16384.0));
   endfunction

   function automatic ray_type rand_ray();
      ray_type r;
      if ($urandom_range(0, 9) < 8) begin
         unit_vec(r.dx, r.dy, r.dz);
         unit_vec(r.nx, r.ny, r.nz);
      end else begin
         // non-unit vectors, components from -16384 to 16384
         r.dx = rand_comp(); r.dy = rand_comp(); r.dz = rand_comp();
         r.nx = rand_comp(); r.ny = rand_comp(); r.nz = rand_comp();
      end
      r.frac = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   function automatic ray_type mk(int dx, dy, dz, nx, ny, nz, int fr);
      ray_type r;
      r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
      r.nx = 16'(nx); r.ny = 16'(ny); r.nz = 16'(nz);
      r.frac = 16'(fr);
      return r;
   endfunction

   // hand over queued items and wait for every scatter to come back
   task automatic run_phase();
      feeding = 1'b1;
      wait (ray_queue.size() == 0);
      @(posedge clock);
      while (start) @(posedge clock);
      feeding = 1'b0;
      wait (scatter_queue.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(logic [drs_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == drs_pkg::CSR_IOR) ior_q412 = longint'(val[13:0]);
      else eta_q016 = longint'(val);
   endtask

   int ior_set[6] = '{6144, 4096, 16383, 5461, 12000, 4500};
   int eta_set[6] = '{43691, 65535, 16384, 49152, 22370, 58000};

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, entering, leaving, grazing, total internal reflection
      ray_queue.push_back(mk(0, 0, -16384, 0, 0, 16384, 0));
      ray_queue.push_back(mk(0, 0, -16384, 0, 0, 16384, 65535));
      ray_queue.push_back(mk(0, 0, 16384, 0, 0, 16384, 0));
      ray_queue.push_back(mk(0, 0, 16384, 0, 0, 16384, 65535));
      ray_queue.push_back(mk(16384, 0, 0, 0, 0, 16384, 30000));
      ray_queue.push_back(mk(15000, 0, 6500, 0, 0, 16384, 65535));
      ray_queue.push_back(mk(15000, 0, -6500, 0, 0, 16384, 100));
      ray_queue.push_back(mk(11585, 0, 11585, 0, 0, 16384, 40000));
      ray_queue.push_back(mk(-16384, -16384, -16384, 16384, 16384, 16384, 1));
      ray_queue.push_back(mk(16384, 16384, 16384, 16384, 16384, 16384, 32768));
      ray_queue.push_back(mk(-16384, 16384, -16384, -16384, 16384, -16384, 65535));
      ray_queue.push_back(mk(16384, -16384, 16384, 16384, 16384, -16384, 0));
      ray_queue.push_back(mk(0, 0, 0, 0, 0, 0, 12345));
      ray_queue.push_back(mk(-1, -1, -1, 1, 1, 1, 65535));
      ray_queue.push_back(mk(0, 16384, 0, 0, -16384, 0, 5));
      ray_queue.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, 7));
      ray_queue.push_back(mk(32767, -32768, 32767, 32767, 32767, -32768, 60000));
      run_phase();

      // random part under a range of register settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            write_csr(drs_pkg::CSR_IOR, 16'(ior_set[ph]));
            write_csr(drs_pkg::CSR_ETA, 16'(eta_set[ph]));
            // r0 is recomputed after an index write, busy covers it
         end
         for (int i = 0; i < 270; i++) ray_queue.push_back(rand_ray());
         run_phase();
      end

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
rtl/drs_pkg.sv
rtl/drs_isqrt.sv
rtl/drs_r0_unit.sv
rtl/dielectric_refract_schlick_core.sv
dv/tb_top.sv
